FILE: rtl/core/rbt_pkg.sv
// Shared types and constants for the reference-counted barrier table.
// Used by the interfaces, the controller, the datapath and the checker.
// No dependencies.
package rbt_pkg;

    localparam int KEY_W          = 64;
    localparam int CNT_W          = 32;
    localparam int DELTA_W        = 16;
    localparam int STATUS_W       = 3;
    localparam int LIVE_W         = 5;
    localparam int DEFAULT_DEPTH  = 16;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_UNKNOWN,
        ST_OVER_RELEASE,
        ST_OVERFLOW
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_full;
    } t_ctrl_stat;

endpackage

FILE: rtl/core/rbt_if.sv
// Request and response channel interfaces of the barrier table.
// Depends on rbt_pkg for field widths.
interface rbt_req_if;
    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [rbt_pkg::KEY_W-1:0]      commit_id;
    logic [rbt_pkg::DELTA_W-1:0]    ref_delta;

    modport source (output valid, output req_type, output commit_id, output ref_delta,
                    input ready);
    modport sink   (input valid, input req_type, input commit_id, input ref_delta,
                    output ready);
endinterface

interface rbt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rbt_pkg::STATUS_W-1:0]   status;
    logic [rbt_pkg::CNT_W-1:0]      entry_count;
    logic [rbt_pkg::KEY_W-1:0]      min_commit_id;
    logic [rbt_pkg::KEY_W-1:0]      max_commit_id;
    logic                           is_empty;
    logic [rbt_pkg::LIVE_W-1:0]     live_entries;

    modport source (output valid, output status, output entry_count, output min_commit_id,
                    output max_commit_id, output is_empty, output live_entries,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input min_commit_id,
                    input max_commit_id, input is_empty, input live_entries,
                    output ready);
endinterface

FILE: rtl/core/rbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rbt_ctrl.sv
// Sequencer of the barrier table: accept, scan the table, commit.
// Depends on rbt_pkg for the command and status structs.
module rbt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rbt_pkg::t_ctrl_stat i_stat,
    output rbt_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the output register can take the result
                if (!i_stat.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_COMMIT) && !i_stat.out_full;

endmodule

FILE: rtl/core/rbt_dp.sv
// Datapath of the barrier table: entry RAM, valid bits, scan accumulators,
// update decision and output register. Depends on rbt_pkg and rbt_ram.
module rbt_dp #(
    parameter int TABLE_DEPTH = rbt_pkg::DEFAULT_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rbt_pkg::t_ctrl_cmd              i_cmd,
    output rbt_pkg::t_ctrl_stat             o_stat,
    input  logic                            i_req_type,
    input  logic [rbt_pkg::KEY_W-1:0]       i_commit_id,
    input  logic [rbt_pkg::DELTA_W-1:0]     i_ref_delta,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rbt_pkg::STATUS_W-1:0]    o_status,
    output logic [rbt_pkg::CNT_W-1:0]       o_entry_count,
    output logic [rbt_pkg::KEY_W-1:0]       o_min_commit_id,
    output logic [rbt_pkg::KEY_W-1:0]       o_max_commit_id,
    output logic                            o_is_empty,
    output logic [rbt_pkg::LIVE_W-1:0]      o_live_entries
);

    localparam int KW = rbt_pkg::KEY_W;
    localparam int NW = rbt_pkg::CNT_W;
    localparam int DW = rbt_pkg::DELTA_W;
    localparam int EW = KW + NW;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // captured request
    logic          r_req_type;
    logic [KW-1:0] r_key;
    logic [DW-1:0] r_delta;

    // scan state
    logic [CW-1:0] r_issue;
    logic          r_pend;
    logic [AW-1:0] r_cmp_addr;
    logic          r_hit;
    logic [AW-1:0] r_hit_idx;
    logic [NW-1:0] r_hit_cnt;
    logic          r_free_ok;
    logic [AW-1:0] r_free_idx;
    logic [KW-1:0] r_min;
    logic [KW-1:0] r_max;
    logic [CW-1:0] r_others;

    logic [TABLE_DEPTH-1:0] r_valid;

    // output register
    logic                           r_out_valid;
    logic [rbt_pkg::STATUS_W-1:0]   r_o_status;
    logic [NW-1:0]                  r_o_count;
    logic [KW-1:0]                  r_o_min;
    logic [KW-1:0]                  r_o_max;
    logic                           r_o_empty;
    logic [rbt_pkg::LIVE_W-1:0]     r_o_live;

    // RAM ports
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [NW-1:0] w_wcnt;
    logic [KW-1:0] w_rd_key;
    logic [NW-1:0] w_rd_cnt;
    logic          w_ent_valid;
    logic          w_match;

    // commit decision
    rbt_pkg::t_status w_status;
    logic [NW-1:0]    w_count;
    logic             w_key_live;
    logic             w_set_valid;
    logic             w_clr_valid;
    logic [NW:0]      w_sum;
    logic [NW-1:0]    w_rest;
    logic             w_under;
    logic [KW-1:0]    w_new_min;
    logic [KW-1:0]    w_new_max;
    logic [CW-1:0]    w_live;

    rbt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_key, w_wcnt}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_re        = i_cmd.scan && (r_issue != CW'(TABLE_DEPTH));
    assign w_raddr     = r_issue[AW-1:0];
    assign w_rd_key    = w_rdata[EW-1:NW];
    assign w_rd_cnt    = w_rdata[NW-1:0];
    assign w_ent_valid = r_valid[r_cmp_addr];
    assign w_match     = w_ent_valid && (w_rd_key == r_key);

    assign o_stat.scan_done = (r_issue == CW'(TABLE_DEPTH)) && !r_pend;
    assign o_stat.out_full  = r_out_valid && !i_out_ready;

    assign w_sum   = {1'b0, r_hit_cnt} + {{(NW + 1 - DW){1'b0}}, r_delta};
    assign w_rest  = r_hit_cnt - {{(NW - DW){1'b0}}, r_delta};
    assign w_under = r_hit_cnt < {{(NW - DW){1'b0}}, r_delta};

    always_comb begin
        w_status    = rbt_pkg::ST_OK;
        w_count     = '0;
        w_key_live  = 1'b0;
        w_set_valid = 1'b0;
        w_clr_valid = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_hit_idx;
        w_wcnt      = r_hit_cnt;
        case (r_req_type)
            rbt_pkg::REQ_ACQUIRE: begin
                if (r_hit) begin
                    w_key_live = 1'b1;
                    if (w_sum[NW]) begin
                        w_status = rbt_pkg::ST_OVERFLOW;
                        w_count  = r_hit_cnt;
                    end else begin
                        w_count = w_sum[NW-1:0];
                        w_wcnt  = w_sum[NW-1:0];
                        w_we    = i_cmd.commit;
                    end
                end else if (!r_free_ok) begin
                    w_status = rbt_pkg::ST_FULL;
                end else begin
                    w_key_live  = 1'b1;
                    w_count     = NW'(r_delta);
                    w_wcnt      = NW'(r_delta);
                    w_waddr     = r_free_idx;
                    w_we        = i_cmd.commit;
                    w_set_valid = i_cmd.commit;
                end
            end
            rbt_pkg::REQ_RELEASE: begin
                if (!r_hit) begin
                    w_status = rbt_pkg::ST_UNKNOWN;
                end else if (w_under) begin
                    w_status   = rbt_pkg::ST_OVER_RELEASE;
                    w_count    = r_hit_cnt;
                    w_key_live = 1'b1;
                end else begin
                    w_count     = w_rest;
                    w_wcnt      = w_rest;
                    w_we        = i_cmd.commit;
                    w_key_live  = (w_rest != '0);
                    w_clr_valid = i_cmd.commit && (w_rest == '0);
                end
            end
            default: w_status = rbt_pkg::ST_OK;
        endcase
    end

    // fold the request key into the extremes of the other live entries
    assign w_new_min = (w_key_live && (r_key < r_min)) ? r_key : r_min;
    assign w_new_max = (w_key_live && (r_key > r_max)) ? r_key : r_max;
    assign w_live    = r_others + CW'(w_key_live);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= w_re;
            if (w_set_valid) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_clr_valid) begin
                r_valid[w_waddr] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, scan accumulators and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_key      <= i_commit_id;
            r_delta    <= i_ref_delta;
            r_issue    <= '0;
            r_hit      <= 1'b0;
            r_free_ok  <= 1'b0;
            r_min      <= '1;
            r_max      <= '0;
            r_others   <= '0;
        end else begin
            if (w_re) begin
                r_issue <= r_issue + CW'(1);
            end
            if (r_pend) begin
                if (w_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_addr;
                    r_hit_cnt <= w_rd_cnt;
                end
                if (!w_ent_valid && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_cmp_addr;
                end
                if (w_ent_valid && !w_match) begin
                    r_others <= r_others + CW'(1);
                    if (w_rd_key < r_min) begin
                        r_min <= w_rd_key;
                    end
                    if (w_rd_key > r_max) begin
                        r_max <= w_rd_key;
                    end
                end
            end
        end
        r_cmp_addr <= w_raddr;
        if (i_cmd.commit) begin
            r_o_status <= w_status;
            r_o_count  <= w_count;
            r_o_min    <= w_new_min;
            r_o_max    <= w_new_max;
            r_o_empty  <= (w_live == '0);
            r_o_live   <= rbt_pkg::LIVE_W'(w_live);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_entry_count   = r_o_count;
    assign o_min_commit_id = r_o_min;
    assign o_max_commit_id = r_o_max;
    assign o_is_empty      = r_o_empty;
    assign o_live_entries  = r_o_live;

endmodule

FILE: rtl/core/refcounted_barrier_table.sv
// Top level of the reference-counted barrier table.
// Depends on rbt_pkg, rbt_if, rbt_ctrl and rbt_dp.
//
//  channel  | dir | modport | transaction
//  ---------+-----+---------+----------------------------------------------
//  i_req    | in  | sink    | req_type, commit_id, ref_delta
//  o_rsp    | out | source  | status, entry_count, min/max id, is_empty, live
//
// A request is accepted, then the table is scanned one entry a cycle through the
// single read port of the entry RAM, then the commit step writes back and loads
// the output register.
// A new request is accepted as soon as the previous result sits in the output
// register, even while the sink stalls; a second result waits in the commit step.
// Reset is synchronous, active low, and empties the table at once.
module refcounted_barrier_table #(
    parameter int TABLE_DEPTH = rbt_pkg::DEFAULT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbt_req_if.sink   i_req,
    rbt_rsp_if.source o_rsp
);

    rbt_pkg::t_ctrl_cmd  w_cmd;
    rbt_pkg::t_ctrl_stat w_stat;

    rbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rbt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_req_type      (i_req.req_type),
        .i_commit_id     (i_req.commit_id),
        .i_ref_delta     (i_req.ref_delta),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_entry_count   (o_rsp.entry_count),
        .o_min_commit_id (o_rsp.min_commit_id),
        .o_max_commit_id (o_rsp.max_commit_id),
        .o_is_empty      (o_rsp.is_empty),
        .o_live_entries  (o_rsp.live_entries)
    );

endmodule

FILE: rtl/core/rbt_checker.sv
// Port-level checks for the barrier table, bound to the top level.
// Depends on rbt_pkg and refcounted_barrier_table.
module rbt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [rbt_pkg::STATUS_W-1:0]   i_status,
    input logic [rbt_pkg::CNT_W-1:0]      i_entry_count,
    input logic [rbt_pkg::KEY_W-1:0]      i_min_commit_id,
    input logic [rbt_pkg::KEY_W-1:0]      i_max_commit_id,
    input logic                           i_is_empty,
    input logic [rbt_pkg::LIVE_W-1:0]     i_live_entries
);

    // one request at a time: no acceptance right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while one is in progress");

    // an empty table reports no entries and the empty extremes
    a_empty_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_is_empty) |->
            (i_live_entries == '0) && (i_min_commit_id == '1) && (i_max_commit_id == '0))
        else $error("empty table with non-empty extremes");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_is_empty) |-> (i_min_commit_id <= i_max_commit_id))
        else $error("minimum above maximum");

    // a failed lookup or a full table reports a zero count
    a_absent_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && ((i_status == rbt_pkg::ST_FULL) || (i_status == rbt_pkg::ST_UNKNOWN)))
            |-> (i_entry_count == '0))
        else $error("non-zero count for an absent entry");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status) && $stable(i_entry_count)
             && $stable(i_min_commit_id) && $stable(i_max_commit_id)))
        else $error("stalled response changed");

endmodule

bind refcounted_barrier_table rbt_checker u_rbt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_entry_count   (o_rsp.entry_count),
    .i_min_commit_id (o_rsp.min_commit_id),
    .i_max_commit_id (o_rsp.max_commit_id),
    .i_is_empty      (o_rsp.is_empty),
    .i_live_entries  (o_rsp.live_entries)
);

FILE: verif/tb_refcounted_barrier_table.sv
`timescale 1ns / 1ps
// Testbench for refcounted_barrier_table: directed and random acquire/release traffic,
// each response checked field by field against a behavioural mirror of the table.
// Depends on rbt_pkg, the rbt_req_if/rbt_rsp_if interfaces and the block's RTL.
module tb_refcounted_barrier_table;

    localparam int DEPTH       = rbt_pkg::DEFAULT_DEPTH;
    localparam int QUIET_LIMIT = 2000;
    localparam int POOL_SIZE   = 24;
    localparam int CLIMB_STEPS = 16;

    localparam logic [rbt_pkg::KEY_W-1:0]   KEY_ONES  = '1;
    localparam logic [rbt_pkg::KEY_W-1:0]   KEY_ZERO  = '0;
    localparam logic [rbt_pkg::DELTA_W-1:0] DELTA_MAX = '1;

    typedef struct {
        rbt_pkg::t_status                status;
        logic [rbt_pkg::CNT_W-1:0]       entry_count;
        logic [rbt_pkg::KEY_W-1:0]       min_id;
        logic [rbt_pkg::KEY_W-1:0]       max_id;
        logic                            is_empty;
        logic [rbt_pkg::LIVE_W-1:0]      live;
    } t_barrier_result;

    logic clk;
    logic rst_n;

    rbt_req_if req_if ();
    rbt_rsp_if rsp_if ();

    refcounted_barrier_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Mirror of the barrier table, updated when a request transaction is accepted
    logic [rbt_pkg::KEY_W-1:0] mirror_key   [DEPTH];
    logic [rbt_pkg::CNT_W-1:0] mirror_count [DEPTH];
    logic                      mirror_live  [DEPTH];

    t_barrier_result           pending_results [$];
    logic [rbt_pkg::KEY_W-1:0] id_pool [POOL_SIZE];
    int                        errors;
    bit                        sender_idle;
    bit                        sink_idle;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rbt_pkg::DELTA_W-1:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return rbt_pkg::DELTA_W'($urandom_range(1, 8));
        if (r < 75)
            return rbt_pkg::DELTA_W'($urandom_range(0, 255));
        if (r < 95)
            return rbt_pkg::DELTA_W'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? DELTA_MAX : '0;
    endfunction

    // Mostly a legal release (often the exact count), sometimes an over-release
    function automatic logic [rbt_pkg::DELTA_W-1:0] pick_release_delta(
            input logic [rbt_pkg::CNT_W-1:0] have);
        logic [rbt_pkg::CNT_W-1:0] cap;
        int r;
        cap = (have > DELTA_MAX) ? rbt_pkg::CNT_W'(DELTA_MAX) : have;
        r = $urandom_range(0, 99);
        if (r < 50)
            return cap[rbt_pkg::DELTA_W-1:0];
        if (r < 85)
            return rbt_pkg::DELTA_W'($urandom_range(0, cap));
        if (have < DELTA_MAX)
            return rbt_pkg::DELTA_W'($urandom_range(have + 1, DELTA_MAX));
        return cap[rbt_pkg::DELTA_W-1:0];
    endfunction

    function automatic t_barrier_result apply_request(
            input logic rtype,
            input logic [rbt_pkg::KEY_W-1:0] id,
            input logic [rbt_pkg::DELTA_W-1:0] delta);
        t_barrier_result r;
        int hit;
        int slot;
        int n_live;
        logic [rbt_pkg::CNT_W:0] sum;
        hit = -1;
        slot = -1;
        n_live = 0;
        r.status = rbt_pkg::ST_OK;
        r.entry_count = '0;
        r.min_id = KEY_ONES;
        r.max_id = KEY_ZERO;
        for (int i = 0; i < DEPTH; i++) begin
            if (mirror_live[i] && mirror_key[i] == id && hit < 0)
                hit = i;
            if (!mirror_live[i] && slot < 0)
                slot = i;
        end
        if (rtype == rbt_pkg::REQ_ACQUIRE) begin
            if (hit >= 0) begin
                sum = {1'b0, mirror_count[hit]} + delta;
                if (sum[rbt_pkg::CNT_W]) begin
                    r.status = rbt_pkg::ST_OVERFLOW;
                    r.entry_count = mirror_count[hit];
                end else begin
                    mirror_count[hit] = sum[rbt_pkg::CNT_W-1:0];
                    r.entry_count = sum[rbt_pkg::CNT_W-1:0];
                end
            end else if (slot < 0) begin
                r.status = rbt_pkg::ST_FULL;
            end else begin
                // New entries take the lowest free slot
                mirror_live[slot] = 1'b1;
                mirror_key[slot] = id;
                mirror_count[slot] = rbt_pkg::CNT_W'(delta);
                r.entry_count = rbt_pkg::CNT_W'(delta);
            end
        end else begin
            if (hit < 0) begin
                r.status = rbt_pkg::ST_UNKNOWN;
            end else if (mirror_count[hit] < delta) begin
                r.status = rbt_pkg::ST_OVER_RELEASE;
                r.entry_count = mirror_count[hit];
            end else begin
                mirror_count[hit] = mirror_count[hit] - delta;
                if (mirror_count[hit] == '0)
                    mirror_live[hit] = 1'b0;
                r.entry_count = mirror_count[hit];
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (mirror_live[i]) begin
                n_live++;
                if (mirror_key[i] < r.min_id)
                    r.min_id = mirror_key[i];
                if (mirror_key[i] > r.max_id)
                    r.max_id = mirror_key[i];
            end
        end
        r.is_empty = (n_live == 0);
        r.live = rbt_pkg::LIVE_W'(n_live);
        return r;
    endfunction

    // Present one request and hold it until accepted; valid stays high afterwards
    // so that a back-to-back request needs no second assignment in the same step.
    task automatic send_request(input logic rtype, input logic [rbt_pkg::KEY_W-1:0] id,
                                input logic [rbt_pkg::DELTA_W-1:0] delta);
        int gap;
        gap = (sender_idle && $urandom_range(0, 1)) ? pick_idle() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rtype;
        req_if.commit_id <= id;
        req_if.ref_delta <= delta;
        do @(posedge clk); while (!req_if.ready);
        pending_results.insert(pending_results.size(), apply_request(rtype, id, delta));
    endtask

    task automatic compare_field(input string what, input logic [rbt_pkg::KEY_W-1:0] want,
                                 input logic [rbt_pkg::KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic check_response();
        t_barrier_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: response with no request outstanding: expected none, %s %0h",
                     $time, "actual status", rsp_if.status);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", rbt_pkg::KEY_W'(want.status),
                      rbt_pkg::KEY_W'(rsp_if.status));
        compare_field("entry_count", rbt_pkg::KEY_W'(want.entry_count),
                      rbt_pkg::KEY_W'(rsp_if.entry_count));
        compare_field("min_commit_id", want.min_id, rsp_if.min_commit_id);
        compare_field("max_commit_id", want.max_id, rsp_if.max_commit_id);
        compare_field("is_empty", rbt_pkg::KEY_W'(want.is_empty),
                      rbt_pkg::KEY_W'(rsp_if.is_empty));
        compare_field("live_entries", rbt_pkg::KEY_W'(want.live),
                      rbt_pkg::KEY_W'(rsp_if.live_entries));
    endtask

    // Response sink: check each transaction, then choose ready for the next cycle
    initial begin
        int hold;
        hold = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                check_response();
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if (sink_idle && $urandom_range(0, 2) == 0)
                    hold = pick_idle();
            end
        end
    end

    // Watchdog: end the run when no transaction moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic test_empty_and_extremes();
        send_request(rbt_pkg::REQ_RELEASE, KEY_ONES, 16'd1);
        send_request(rbt_pkg::REQ_ACQUIRE, KEY_ZERO, DELTA_MAX);
        send_request(rbt_pkg::REQ_ACQUIRE, KEY_ONES, 16'd1);
        send_request(rbt_pkg::REQ_ACQUIRE, KEY_ZERO, 16'd0);
        send_request(rbt_pkg::REQ_RELEASE, KEY_ONES, 16'd2);
        send_request(rbt_pkg::REQ_RELEASE, KEY_ONES, 16'd1);
        send_request(rbt_pkg::REQ_RELEASE, KEY_ZERO, DELTA_MAX);
    endtask

    task automatic test_zero_delta();
        logic [rbt_pkg::KEY_W-1:0] id;
        id = 64'h5555_aaaa_5555_aaaa;
        // A zero acquire creates a live entry with no references
        send_request(rbt_pkg::REQ_ACQUIRE, id, 16'd0);
        send_request(rbt_pkg::REQ_RELEASE, id, 16'd5);
        send_request(rbt_pkg::REQ_RELEASE, id, 16'd0);
        send_request(rbt_pkg::REQ_RELEASE, id, 16'd0);
        send_request(rbt_pkg::REQ_ACQUIRE, id, 16'd0);
        send_request(rbt_pkg::REQ_ACQUIRE, id, 16'd3);
        send_request(rbt_pkg::REQ_RELEASE, id, 16'd0);
        send_request(rbt_pkg::REQ_RELEASE, id, 16'd3);
    endtask

    task automatic test_table_full();
        for (int k = 0; k < DEPTH; k++)
            send_request(rbt_pkg::REQ_ACQUIRE, id_pool[k], rbt_pkg::DELTA_W'(k + 1));
        send_request(rbt_pkg::REQ_ACQUIRE, id_pool[DEPTH], 16'd7);
        send_request(rbt_pkg::REQ_RELEASE, id_pool[DEPTH], 16'd1);
        send_request(rbt_pkg::REQ_ACQUIRE, id_pool[3], 16'd2);
        send_request(rbt_pkg::REQ_RELEASE, id_pool[0], 16'd1);
        send_request(rbt_pkg::REQ_ACQUIRE, id_pool[DEPTH], 16'd7);
    endtask

    task automatic test_random_traffic(input int n_items);
        int choice;
        int slot;
        int live_slots [$];
        for (int k = 0; k < n_items; k++) begin
            live_slots.delete();
            for (int i = 0; i < DEPTH; i++)
                if (mirror_live[i])
                    live_slots.insert(live_slots.size(), i);
            choice = $urandom_range(0, 99);
            if (choice < 45 || (choice < 80 && live_slots.size() == 0)) begin
                send_request(rbt_pkg::REQ_ACQUIRE,
                             id_pool[$urandom_range(0, POOL_SIZE - 1)], pick_delta());
            end else if (choice < 80) begin
                slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
                send_request(rbt_pkg::REQ_RELEASE, mirror_key[slot],
                             pick_release_delta(mirror_count[slot]));
            end else if (choice < 88) begin
                send_request(rbt_pkg::REQ_RELEASE,
                             id_pool[$urandom_range(0, POOL_SIZE - 1)], pick_delta());
            end else if (choice < 94) begin
                send_request(rbt_pkg::REQ_ACQUIRE, {$urandom, $urandom}, pick_delta());
            end else begin
                send_request(rbt_pkg::REQ_RELEASE, {$urandom, $urandom}, pick_delta());
            end
        end
    endtask

    // Release every live entry down to nothing
    task automatic test_drain_table();
        for (int i = 0; i < DEPTH; i++)
            while (mirror_live[i])
                send_request(rbt_pkg::REQ_RELEASE, mirror_key[i],
                             (mirror_count[i] > DELTA_MAX)
                                 ? DELTA_MAX
                                 : mirror_count[i][rbt_pkg::DELTA_W-1:0]);
    endtask

    // Climb one entry in full-size steps back to back, then step it down again
    task automatic test_large_counts();
        logic [rbt_pkg::KEY_W-1:0] id;
        id = {$urandom, $urandom};
        sender_idle = 1'b0;
        sink_idle = 1'b0;
        for (int k = 0; k < CLIMB_STEPS; k++)
            send_request(rbt_pkg::REQ_ACQUIRE, id, DELTA_MAX);
        send_request(rbt_pkg::REQ_ACQUIRE, id, 16'd1);
        send_request(rbt_pkg::REQ_ACQUIRE, id, 16'd0);
        send_request(rbt_pkg::REQ_RELEASE, id, DELTA_MAX);
        send_request(rbt_pkg::REQ_RELEASE, id, 16'd0);
        send_request(rbt_pkg::REQ_RELEASE, id, 16'd1);
    endtask

    initial begin
        errors = 0;
        sender_idle = 1'b1;
        sink_idle = 1'b1;
        rst_n <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= rbt_pkg::REQ_ACQUIRE;
        req_if.commit_id <= '0;
        req_if.ref_delta <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            mirror_live[i] = 1'b0;
            mirror_key[i] = '0;
            mirror_count[i] = '0;
        end
        id_pool[0] = KEY_ZERO;
        id_pool[1] = KEY_ONES;
        id_pool[2] = 64'd1;
        id_pool[3] = {1'b1, {(rbt_pkg::KEY_W - 1){1'b0}}};
        for (int i = 4; i < POOL_SIZE; i++)
            id_pool[i] = {$urandom, $urandom};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_zero_delta();
        test_table_full();

        test_random_traffic(110);
        sender_idle = 1'b0;
        sink_idle = 1'b0;
        test_random_traffic(110);
        sender_idle = 1'b1;
        test_random_traffic(110);
        sender_idle = 1'b0;
        sink_idle = 1'b1;
        test_random_traffic(110);
        sender_idle = 1'b1;
        test_drain_table();

        test_large_counts();

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rbt_pkg.sv
rtl/core/rbt_if.sv
rtl/core/rbt_ram.sv
rtl/core/rbt_ctrl.sv
rtl/core/rbt_dp.sv
rtl/core/refcounted_barrier_table.sv
rtl/core/rbt_checker.sv
verif/tb_refcounted_barrier_table.sv
